// ===== hdl/xrbc_pkg.sv =====
// shared constants and types for the xor rotate block cipher
package xrbc_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int WORD_BYTES  = CSR_DATA_W / BYTE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1 = 2'd2;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic decrypt;
      logic tail;
   } xrbc_mix_ctrl_type;

endpackage

// ===== hdl/xrbc_mix.sv =====
// square transform: key xor with row and column rotation, or plain xor for a tail
module xrbc_mix
   import xrbc_pkg::*;
#(
   parameter int DIM = 4,
   localparam int KS = DIM * DIM
) (
   input  xrbc_mix_ctrl_type         ctrl,
   input  logic [KS-1:0][BYTE_W-1:0] square,
   input  logic [KS-1:0][BYTE_W-1:0] key_bytes,
   output logic [KS-1:0][BYTE_W-1:0] result
);

   for (genvar r = 0; r < DIM; r++) begin : g_row
      for (genvar c = 0; c < DIM; c++) begin : g_col
         localparam int POS = r * DIM + c;
         localparam int ENC = ((r + 1) % DIM) * DIM + (c + 1) % DIM;
         localparam int DEC = ((r + DIM - 1) % DIM) * DIM + (c + DIM - 1) % DIM;

         always_comb begin
            if (ctrl.tail) begin
               result[POS] = square[POS] ^ key_bytes[POS];
            end else if (ctrl.decrypt) begin
               result[POS] = square[DEC] ^ key_bytes[POS];
            end else begin
               result[POS] = square[ENC] ^ key_bytes[ENC];
            end
         end
      end
   end

endmodule

// ===== hdl/xor_rotate_block_cipher.sv =====
// top level of the xor rotate block cipher: byte gathering, transform and byte output
//
//  port group  dir  payload                        handshake
//  req_        in   req_data_byte, req_last_byte   req_valid / req_stall
//  rsp_        out  rsp_out_byte, rsp_out_last     rsp_valid / rsp_stall
//  csr_        in   csr_index, csr_write_data      csr_write_enable
//
//  one byte per cycle in and out unless stalled; a completed square or tail is
//  transformed in the cycle its final byte is taken and loaded into the output
//  buffer whole; its output starts the next cycle, one byte per unstalled cycle
//  req_stall rises only when a byte would complete a square or tail while the
//  output buffer still holds bytes beyond the one leaving this cycle
//  synchronous reset clears the fill count, output state, mode and key
module xor_rotate_block_cipher
   import xrbc_pkg::*;
#(
   parameter int DIM = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_out_last,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int KS = DIM * DIM;
   localparam int CW = $clog2(KS);

   logic                  mode_ff, mode_in;
   logic [CSR_DATA_W-1:0] kw0_ff, kw0_in;
   logic [CSR_DATA_W-1:0] kw1_ff, kw1_in;

   logic [CW-1:0]             fill_ff, fill_in;
   logic [KS-1:0][BYTE_W-1:0] sq_ff;
   logic [KS-1:0][BYTE_W-1:0] sq_cur;
   logic [KS-1:0][BYTE_W-1:0] key_bytes;
   logic [KS-1:0][BYTE_W-1:0] mix_out;
   logic [KS-1:0][BYTE_W-1:0] ebuf_ff;

   logic          busy_ff, busy_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] end_ff;

   logic              req_acc, rsp_acc;
   logic              full, done, fin, free;
   xrbc_mix_ctrl_type mix_ctrl;

   // configuration registers
   always_comb begin
      mode_in = mode_ff;
      kw0_in  = kw0_ff;
      kw1_in  = kw1_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:       mode_in = csr_write_data[0];
            CSR_KEY_WORD_0: kw0_in  = csr_write_data;
            CSR_KEY_WORD_1: kw1_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   for (genvar j = 0; j < KS; j++) begin : g_key
      if (j < WORD_BYTES) begin : g_lo
         assign key_bytes[j] = kw0_ff[BYTE_W*j +: BYTE_W];
      end else begin : g_hi
         assign key_bytes[j] = kw1_ff[BYTE_W*(j-WORD_BYTES) +: BYTE_W];
      end
      assign sq_cur[j] = (CW'(j) == fill_ff) ? req_data_byte : sq_ff[j];
   end

   // handshake and control
   assign rsp_acc   = busy_ff && !rsp_stall;
   assign fin       = rsp_acc && (idx_ff == end_ff);
   assign free      = !busy_ff || fin;
   assign full      = (fill_ff == CW'(KS - 1));
   assign req_stall = !free && (req_last_byte || full);
   assign req_acc   = req_valid && !req_stall;
   assign done      = req_acc && (full || req_last_byte);

   assign mix_ctrl.decrypt = (mode_ff == MODE_DECRYPT);
   assign mix_ctrl.tail    = !full;

   xrbc_mix #(
      .DIM(DIM)
   ) u_mix (
      .ctrl      (mix_ctrl),
      .square    (sq_cur),
      .key_bytes (key_bytes),
      .result    (mix_out)
   );

   always_comb begin
      fill_in = fill_ff;
      if (req_acc) begin
         fill_in = done ? '0 : fill_ff + CW'(1);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (done) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (fin) begin
         busy_in = 1'b0;
      end else if (rsp_acc) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCRYPT;
         kw0_ff  <= '0;
         kw1_ff  <= '0;
         fill_ff <= '0;
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         kw0_ff  <= kw0_in;
         kw1_ff  <= kw1_in;
         fill_ff <= fill_in;
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         sq_ff[fill_ff] <= req_data_byte;
      end
      if (done) begin
         ebuf_ff <= mix_out;
         end_ff  <= fill_ff;
      end
   end

   assign rsp_valid    = busy_ff;
   assign rsp_out_byte = ebuf_ff[idx_ff];
   assign rsp_out_last = (idx_ff == end_ff);

   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= end_ff))
      else $error("output index past end of buffer");

   a_load_only_when_free : assert property (@(posedge clock) disable iff (reset)
      (done && busy_ff) |-> fin)
      else $error("output buffer overwritten while bytes remain");

   a_load_starts_output : assert property (@(posedge clock) disable iff (reset)
      done |=> (busy_ff && (idx_ff == '0) && (fill_ff == '0)))
      else $error("completed item did not start output");

   a_full_square_length : assert property (@(posedge clock) disable iff (reset)
      (done && full) |=> (end_ff == CW'(KS - 1)))
      else $error("full square length wrong");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the xor rotate block cipher with scoreboard and random traffic
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import xrbc_pkg::*;

   localparam int SQ_DIM     = 4;
   localparam int SQ_SIZE    = SQ_DIM * SQ_DIM;
   localparam int DRAIN_WAIT = 20;
   localparam int PHASES     = 6;
   localparam int PHASE_ITEMS = 28;

   typedef struct {
      byte_type out_byte;
      logic     out_last;
   } cipher_out_type;

   class cipher_scoreboard;
      logic                  mode;
      logic [CSR_DATA_W-1:0] key_lo;
      logic [CSR_DATA_W-1:0] key_hi;
      byte_type              square[SQ_SIZE];
      int                    fill;
      cipher_out_type        expected_out_q[$];
      int                    n_fail;
      int                    n_in;
      int                    n_out;
      int                    n_squares;
      int                    n_tails;

      function new();
         mode = MODE_ENCRYPT;
         key_lo = '0;
         key_hi = '0;
         fill = 0;
         n_fail = 0;
         n_in = 0;
         n_out = 0;
         n_squares = 0;
         n_tails = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_MODE: mode = value[0];
            CSR_KEY_WORD_0: key_lo = value;
            CSR_KEY_WORD_1: key_hi = value;
            default: ;
         endcase
      endfunction

      function byte_type key_at(int j);
         if (j < WORD_BYTES) begin
            return key_lo[BYTE_W*j +: BYTE_W];
         end
         return key_hi[BYTE_W*(j-WORD_BYTES) +: BYTE_W];
      endfunction

      function int pending();
         return expected_out_q.size();
      endfunction

      function void push_out(byte_type b, logic l);
         cipher_out_type e;
         e.out_byte = b;
         e.out_last = l;
         expected_out_q.push_back(e);
      endfunction

      // gathers one message byte and predicts the bytes it releases
      function void absorb_byte(byte_type d, logic l);
         int n;
         int r;
         int c;
         int sp;
         int pos;
         byte_type b;
         n_in++;
         square[fill] = d;
         n = fill + 1;
         if (n == SQ_SIZE) begin
            for (r = 0; r < SQ_DIM; r++) begin
               for (c = 0; c < SQ_DIM; c++) begin
                  pos = r * SQ_DIM + c;
                  if (mode == MODE_ENCRYPT) begin
                     sp = ((r + 1) % SQ_DIM) * SQ_DIM + (c + 1) % SQ_DIM;
                     b = square[sp] ^ key_at(sp);
                  end else begin
                     sp = ((r + SQ_DIM - 1) % SQ_DIM) * SQ_DIM + (c + SQ_DIM - 1) % SQ_DIM;
                     b = square[sp] ^ key_at(pos);
                  end
                  push_out(b, pos == SQ_SIZE - 1);
               end
            end
            fill = 0;
            n_squares++;
         end else if (l) begin
            for (pos = 0; pos < n; pos++) begin
               push_out(square[pos] ^ key_at(pos), pos == n - 1);
            end
            fill = 0;
            n_tails++;
         end else begin
            fill = n;
         end
      endfunction

      function void check_out_byte(byte_type b, logic l);
         cipher_out_type e;
         n_out++;
         if (expected_out_q.size() == 0) begin
            $error("unexpected output item: out_byte %02h out_last %0b", b, l);
            n_fail++;
            return;
         end
         e = expected_out_q.pop_front();
         if (b !== e.out_byte) begin
            $error("out_byte: expected %02h, got %02h", e.out_byte, b);
            n_fail++;
         end
         if (l !== e.out_last) begin
            $error("out_last: expected %0b, got %0b", e.out_last, l);
            n_fail++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_out_last;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   cipher_scoreboard sb;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   xor_rotate_block_cipher #(
      .DIM(SQ_DIM)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.absorb_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_out_byte(rsp_out_byte, rsp_out_last);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) begin
         return 0;
      end else if (r < 18) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 24);
   endfunction

   // receiver: random stalls plus one long hold once traffic is under way
   initial begin
      int stall_left;
      int hold_left;
      bit held;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sb != null && sb.n_in >= 40) begin
            held = 1'b1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!rx_steady && $urandom_range(0, 2) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   task automatic send_byte(input byte_type d, input logic l);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_message(input int len);
      int i;
      for (i = 0; i < len; i++) begin
         send_byte(byte_type'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic apply_config(input logic m, input logic [CSR_DATA_W-1:0] k0,
                               input logic [CSR_DATA_W-1:0] k1);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MODE;
      csr_write_data <= {{(CSR_DATA_W-1){1'b0}}, m};
      @(posedge clock);
      sb.set_reg(CSR_MODE, {{(CSR_DATA_W-1){1'b0}}, m});
      csr_index <= CSR_KEY_WORD_0;
      csr_write_data <= k0;
      @(posedge clock);
      sb.set_reg(CSR_KEY_WORD_0, k0);
      csr_index <= CSR_KEY_WORD_1;
      csr_write_data <= k1;
      @(posedge clock);
      sb.set_reg(CSR_KEY_WORD_1, k1);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int p;
      int i;
      int sent;
      int len;
      int r;
      logic [CSR_DATA_W-1:0] k0;
      logic [CSR_DATA_W-1:0] k1;
      logic m;

      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full square with last on its final byte, then a one-byte tail and a short tail
      apply_config(MODE_ENCRYPT, '1, '0);
      for (i = 0; i < SQ_SIZE; i++) begin
         send_byte(byte_type'(i * 17), i == SQ_SIZE - 1);
      end
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      drain();

      for (p = 0; p < PHASES; p++) begin
         k0 = {$urandom, $urandom};
         k1 = {$urandom, $urandom};
         case (p)
            0: apply_config(MODE_DECRYPT, '0, '1);
            1: apply_config(MODE_ENCRYPT, k0, k1);
            2: apply_config(MODE_DECRYPT, '1, '1);
            3: apply_config(MODE_ENCRYPT, '0, '0);
            4: apply_config(MODE_DECRYPT, k0, k1);
            default: apply_config(MODE_ENCRYPT, k0, k1);
         endcase
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
               len = SQ_SIZE;
            end else if (r == 2) begin
               len = 2 * SQ_SIZE;
            end else if (r < 8) begin
               len = $urandom_range(1, SQ_SIZE - 1);
            end else if (r == 8) begin
               len = $urandom_range(SQ_SIZE + 1, 40);
            end else begin
               len = 0;
            end
            if (len > 0) begin
               send_message(len);
               sent += len;
            end else begin
               // noise: bytes with random end markers
               len = $urandom_range(1, 6);
               for (i = 0; i < len; i++) begin
                  send_byte(byte_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
               sent += len;
            end
         end
         // leave part of a square behind so the next settings apply mid-square
         len = $urandom_range(0, 5);
         for (i = 0; i < len; i++) begin
            send_byte(byte_type'($urandom_range(0, 255)), 1'b0);
         end
         drain();
      end

      // flush whatever partial square is still held
      m = 1'($urandom_range(0, 1));
      apply_config(m, {$urandom, $urandom}, {$urandom, $urandom});
      send_byte(byte_type'($urandom_range(0, 255)), 1'b1);
      drain();

      if (sb.pending() != 0) begin
         $error("%0d expected output items never arrived", sb.pending());
         sb.n_fail++;
      end
      $display("run: %0d bytes in, %0d bytes out, %0d squares, %0d tails",
               sb.n_in, sb.n_out, sb.n_squares, sb.n_tails);
      $display("run: both directions, key extremes, mid-square setting changes, long output hold");
      if (sb.n_fail == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== xor_rotate_block_cipher.f =====
hdl/xrbc_pkg.sv
hdl/xrbc_mix.sv
hdl/xor_rotate_block_cipher.sv
tb/tb_top.sv
